>>> src/gga_pkg.sv
// shared types, constants and helpers of the gga sentence field extractor
// no dependencies; imported by every module of the block
package gga_pkg;

	localparam int FIELD_CHARS = 15;
	localparam int NUM_FIELDS  = 3;
	localparam int NUM_BANKS   = 2;
	localparam int STORE_DEPTH = NUM_BANKS * NUM_FIELDS * FIELD_CHARS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int LEN_W       = $clog2(FIELD_CHARS + 1);
	localparam int FID_W       = 2;
	localparam int IDX_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int OUT_DATA_W  = 16;
	localparam int OUT_USER_W  = 3;

	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [FID_W-1:0]  fid_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// header tracking
	localparam logic [2:0] HDR_LEN = 3'd6;
	localparam logic [2:0] HDR_BAD = 3'd7;

	// characters of interest
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LAT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LON   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd3;

	localparam idx_t MAX_COMMAS = 4'd15;
	localparam idx_t RST_LAT    = 4'd2;
	localparam idx_t RST_LON    = 4'd4;
	localparam idx_t RST_ALT    = 4'd9;
	localparam idx_t RST_TOTAL  = 4'd14;

	// configuration as seen by the front end
	typedef struct packed {
		idx_t [NUM_FIELDS-1:0] idx;
		idx_t                  total;
	} cfg_t;

	// one finished sentence, handed from front to back
	typedef struct packed {
		logic                  bank;
		logic                  ok;
		len_t [NUM_FIELDS-1:0] len;
		logic [NUM_FIELDS-1:0] trunc;
		fid_t [NUM_FIELDS-1:0] src;
	} cmd_t;

	// store write request
	typedef struct packed {
		logic       en;
		addr_t      addr;
		logic [7:0] data;
	} wr_t;

	// expected header text by position
	function automatic logic [7:0] header_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = 8'h24; // '$'
			3'd1:    c = 8'h47; // 'G'
			3'd2:    c = 8'h50; // 'P'
			3'd3:    c = 8'h47; // 'G'
			3'd4:    c = 8'h47; // 'G'
			3'd5:    c = 8'h41; // 'A'
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// store address of one character
	function automatic addr_t store_addr(input logic bank, input fid_t f, input len_t i);
		int a;
		a = int'(bank) * (NUM_FIELDS * FIELD_CHARS) + int'(f) * FIELD_CHARS + int'(i);
		return addr_t'(a);
	endfunction

endpackage

>>> src/gga_front.sv
// front end: accepts received bytes, tracks header, commas and field capture
// depends on gga_pkg; feeds gga_cmdq and the store write port in gga_back
module gga_front (
	input  logic          clk,
	input  logic          arst_n,
	input  gga_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          q_full,
	output logic          push,
	output gga_pkg::cmd_t cmd,
	output gga_pkg::wr_t  wr
);
	import gga_pkg::*;

	logic                  in_sent_q;
	logic [2:0]            hpos_q;
	logic                  hmatch_q;
	idx_t                  ccount_q;
	logic                  ovf_q;
	logic                  star_q;
	len_t [NUM_FIELDS-1:0] len_q;
	logic [NUM_FIELDS-1:0] trunc_q;
	logic                  halted_q;
	logic                  bank_q;

	logic                  fire;
	logic                  live;
	logic                  body;
	logic                  capture;
	logic [NUM_FIELDS-1:0] match;
	logic                  any_match;
	fid_t                  first;
	logic                  fail;

	// a byte can always be taken unless both store banks hold pending sentences
	assign in_ready = halted_q | ~q_full;
	assign fire     = in_valid & in_ready;
	assign live     = fire & ~halted_q & (in_byte != CH_DOLLAR) & in_sent_q;
	assign body     = live & (in_byte != CH_NL) & hmatch_q;
	assign capture  = body & (in_byte != CH_COMMA) & ~ovf_q;

	// fields whose start comma is the current one; lowest one owns the store
	always_comb begin
		match     = '0;
		any_match = 1'b0;
		first     = '0;
		for (int f = NUM_FIELDS - 1; f >= 0; f--) begin
			match[f] = (cfg.idx[f] != '0) && (cfg.idx[f] == ccount_q);
			if (match[f]) begin
				any_match = 1'b1;
				first     = fid_t'(f);
			end
		end
	end

	assign wr.en   = capture & any_match & (len_q[first] < len_t'(FIELD_CHARS));
	assign wr.addr = store_addr(bank_q, first, len_q[first]);
	assign wr.data = in_byte;

	// sentence end check
	assign fail = ovf_q | (ccount_q != cfg.total) | ~star_q;
	assign push = live & (in_byte == CH_NL) & hmatch_q;

	// summary item; fields sharing an index read the lowest one's characters
	always_comb begin
		cmd.bank  = bank_q;
		cmd.ok    = ~fail;
		cmd.len   = len_q;
		cmd.trunc = trunc_q;
		for (int f = 0; f < NUM_FIELDS; f++) begin
			cmd.src[f] = fid_t'(f);
			for (int g = f; g >= 0; g--) begin
				if (cfg.idx[g] == cfg.idx[f]) begin
					cmd.src[f] = fid_t'(g);
				end
			end
		end
	end

	// sentence parsing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0;
			hpos_q    <= '0;
			hmatch_q  <= 1'b0;
			ccount_q  <= '0;
			ovf_q     <= 1'b0;
			star_q    <= 1'b0;
			len_q     <= '0;
			trunc_q   <= '0;
			halted_q  <= 1'b0;
			bank_q    <= 1'b0;
		end else if (fire && !halted_q) begin
			if (in_byte == CH_DOLLAR) begin
				in_sent_q <= 1'b1;
				hpos_q    <= 3'd1;
				hmatch_q  <= 1'b0;
				ccount_q  <= '0;
				ovf_q     <= 1'b0;
				star_q    <= 1'b0;
				len_q     <= '0;
				trunc_q   <= '0;
			end else if (in_sent_q) begin
				if (in_byte == CH_NL) begin
					in_sent_q <= 1'b0;
					if (hmatch_q) begin
						bank_q <= ~bank_q;
						if (fail) begin
							halted_q <= 1'b1;
						end
					end
				end else if (!hmatch_q) begin
					if (hpos_q < HDR_LEN) begin
						if (in_byte == header_char(hpos_q)) begin
							hpos_q <= hpos_q + 3'd1;
							if (hpos_q + 3'd1 == HDR_LEN) begin
								hmatch_q <= 1'b1;
							end
						end else begin
							hpos_q <= HDR_BAD;
						end
					end
				end else if (in_byte == CH_COMMA) begin
					if (ccount_q == MAX_COMMAS) begin
						ovf_q <= 1'b1;
					end else begin
						ccount_q <= ccount_q + idx_t'(1);
					end
					star_q <= 1'b0;
				end else begin
					if (in_byte == CH_STAR) begin
						star_q <= 1'b1;
					end
					if (!ovf_q) begin
						for (int f = 0; f < NUM_FIELDS; f++) begin
							if (match[f]) begin
								if (len_q[f] < len_t'(FIELD_CHARS)) begin
									len_q[f] <= len_q[f] + len_t'(1);
								end else begin
									trunc_q[f] <= 1'b1;
								end
							end
						end
					end
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) halted_q |=> halted_q)
		else $error("halt released without reset");
	assert property (@(posedge clk) disable iff (!arst_n) (push && !cmd.ok) |=> halted_q)
		else $error("failed sentence did not halt");

endmodule

>>> src/gga_cmdq.sv
// two-entry queue of finished sentence summaries between front and back
// depends on gga_pkg
module gga_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gga_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          head_valid,
	output gga_pkg::cmd_t head,
	output logic          full
);
	import gga_pkg::*;

	cmd_t       ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign head_valid = (cnt_q != 2'd0);
	assign full       = (cnt_q == 2'd2);
	assign head       = ent_q[rptr_q];

	// entries carry payload only
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

>>> src/gga_back.sv
// back end: field character store and result sequencer with output register
// depends on gga_pkg; reads sentence summaries from gga_cmdq
module gga_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gga_pkg::wr_t                       wr,
	input  logic                               head_valid,
	input  gga_pkg::cmd_t                      head,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [gga_pkg::OUT_DATA_W-1:0]     out_data,
	output logic [gga_pkg::OUT_USER_W-1:0]     out_user,
	output logic                               out_last
);
	import gga_pkg::*;

	logic [7:0] store_q [STORE_DEPTH];

	fid_t       cur_f_q;
	len_t       cur_i_q;
	logic       rd_pend_s1;
	logic [7:0] rdata_s1;
	fid_t       fid_s1;
	logic       tr_s1;
	logic       last_s1;

	logic       out_valid_q;
	fid_t       o_fid_q;
	logic [7:0] o_char_q;
	logic       o_cv_q;
	logic       o_ok_q;
	logic       o_tr_q;
	logic       o_last_q;

	logic       out_free;
	logic       all_empty;
	logic       status;
	logic       status_load;
	logic       fields_done;
	len_t       cur_len;
	fid_t       cur_src;
	logic       cur_tr;
	logic       later_empty;
	logic       rd_en;
	logic       skip;
	addr_t      rd_addr;

	assign out_free    = ~out_valid_q | out_ready;
	assign fields_done = (cur_f_q == fid_t'(NUM_FIELDS));

	// per-field selection for the field being walked
	always_comb begin
		all_empty   = 1'b1;
		cur_len     = '0;
		cur_src     = '0;
		cur_tr      = 1'b0;
		later_empty = 1'b1;
		for (int f = 0; f < NUM_FIELDS; f++) begin
			if (head.len[f] != '0) begin
				all_empty = 1'b0;
			end
			if (fid_t'(f) == cur_f_q) begin
				cur_len = head.len[f];
				cur_src = head.src[f];
				cur_tr  = head.trunc[f];
			end
			if (fid_t'(f) > cur_f_q && head.len[f] != '0) begin
				later_empty = 1'b0;
			end
		end
	end

	// failed or empty sentence gives a single status item
	assign status      = head_valid & (~head.ok | all_empty);
	assign status_load = status & ~rd_pend_s1 & out_free;
	assign rd_en       = head_valid & ~status & ~rd_pend_s1 & ~fields_done
		& (cur_i_q != cur_len) & out_free;
	assign skip        = head_valid & ~status & ~rd_pend_s1 & ~fields_done
		& (cur_i_q == cur_len);
	assign pop         = head_valid & ~rd_pend_s1 & (status ? out_free : fields_done);
	assign rd_addr     = store_addr(head.bank, cur_src, cur_i_q);

	// character store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_s1 <= store_q[rd_addr];
			fid_s1   <= cur_f_q;
			tr_s1    <= cur_tr;
			last_s1  <= (len_t'(cur_i_q + len_t'(1)) == cur_len) & later_empty;
		end
	end

	// walk over fields and characters of the head sentence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_f_q    <= '0;
			cur_i_q    <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_en;
			if (pop) begin
				cur_f_q <= '0;
				cur_i_q <= '0;
			end else if (rd_en) begin
				cur_i_q <= cur_i_q + len_t'(1);
			end else if (skip) begin
				cur_f_q <= cur_f_q + fid_t'(1);
				cur_i_q <= '0;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_pend_s1 || status_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			o_fid_q  <= fid_s1;
			o_char_q <= rdata_s1;
			o_cv_q   <= 1'b1;
			o_ok_q   <= 1'b1;
			o_tr_q   <= tr_s1;
			o_last_q <= last_s1;
		end else if (status_load) begin
			o_fid_q  <= '0;
			o_char_q <= '0;
			o_cv_q   <= 1'b0;
			o_ok_q   <= head.ok;
			o_tr_q   <= 1'b0;
			o_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {6'b000000, o_tr_q, o_ok_q, o_char_q};
	assign out_user  = {o_cv_q, o_fid_q};
	assign out_last  = o_last_q;

	assert property (@(posedge clk) disable iff (!arst_n) rd_pend_s1 |-> !out_valid_q)
		else $error("store data arrived while output register busy");
	assert property (@(posedge clk) disable iff (!arst_n) (out_valid_q && o_cv_q) |-> o_ok_q)
		else $error("character item from a failed sentence");

endmodule

>>> src/nmea_gga_field_extractor.sv
// gga sentence field extractor, top level: config registers and block wiring
// depends on gga_pkg, gga_front, gga_cmdq, gga_back
// input: one byte per cycle; it stalls only while two finished sentences await output
// output: status items and characters pass through the output register; characters come from a
//   registered store read, one read at a time; each field change takes a skip step
// reset: asynchronous, clears control state and loads register defaults; store not cleared
module nmea_gga_field_extractor (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] char_byte, [8] sentence_ok, [9] field_truncated, [15:10] zero
	output logic [gga_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [gga_pkg::OUT_USER_W-1:0] m_axis_tuser,  // [1:0] field_id, [2] char_valid
	output logic                           m_axis_tlast,  // last
	// configuration write port
	input  logic                           cfg_we,
	input  logic [gga_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gga_pkg::IDX_W-1:0]      cfg_wdata
);
	import gga_pkg::*;

	cfg_t cfg_q;
	logic q_full;
	logic push;
	cmd_t push_cmd;
	wr_t  wr;
	logic head_valid;
	cmd_t head;
	logic pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idx[0] <= RST_LAT;
			cfg_q.idx[1] <= RST_LON;
			cfg_q.idx[2] <= RST_ALT;
			cfg_q.total  <= RST_TOTAL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LAT:   cfg_q.idx[0] <= cfg_wdata;
				REG_LON:   cfg_q.idx[1] <= cfg_wdata;
				REG_ALT:   cfg_q.idx[2] <= cfg_wdata;
				REG_TOTAL: cfg_q.total  <= cfg_wdata;
				default:   cfg_q        <= cfg_q;
			endcase
		end
	end

	gga_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd),
		.wr       (wr)
	);

	gga_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.full       (q_full)
	);

	gga_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_user   (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

endmodule
